// ----- src/wma_pkg.sv -----
package wma_pkg;

	// Fixed widths of the item fields and the configuration register.
	localparam int SAMPLE_W = 16;
	localparam int CFG_W = 4;

	// Default largest window, as log2 of its length.
	localparam int MAX_WINDOW_LOG2_DEF = 8;

	// Window register value after reset.
	localparam logic [CFG_W-1:0] WINDOW_LOG2_RESET = 4'd3;

	// Entries in the queue between the window update and the divider.
	localparam int QUEUE_DEPTH_DEF = 2;

endpackage

// ----- src/wma_queue.sv -----
module wma_queue #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    level_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (level_q == NW'(DEPTH));
	assign empty    = (level_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop && !empty) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push && !full, pop && !empty})
				2'b10:   level_q <= level_q + NW'(1);
				2'b01:   level_q <= level_q - NW'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	// The front only pushes when there is room, and the back only pops a held entry.
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue popped while empty");

endmodule

// ----- src/wma_front.sv -----
module wma_front
	import wma_pkg::*;
#(
	parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_LOG2_DEF,
	localparam int AW = MAX_WINDOW_LOG2,
	localparam int CW = MAX_WINDOW_LOG2 + 1,
	localparam int SW = SAMPLE_W + MAX_WINDOW_LOG2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                window_log2_we,
	input  logic [CFG_W-1:0]    window_log2,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                push,
	output logic [SW+CW-1:0]    push_data,
	input  logic                full
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]          state_q;
	logic [CFG_W-1:0]    window_log2_q;
	logic [SW-1:0]       sum_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       wptr_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [AW-1:0]       ptr_s1;
	logic [SAMPLE_W-1:0] rd_q;
	logic [SAMPLE_W-1:0] store_q [2**AW];

	logic [CFG_W-1:0] eff_log2;
	logic [CW-1:0]    size;
	logic [AW-1:0]    mask;
	logic [AW-1:0]    ptr;
	logic             accept;
	logic             window_full;
	logic [SW-1:0]    new_ext;
	logic [SW-1:0]    old_ext;

	assign eff_log2 = (window_log2_q > CFG_W'(MAX_WINDOW_LOG2)) ?
		CFG_W'(MAX_WINDOW_LOG2) : window_log2_q;
	assign size        = CW'(1) << eff_log2;
	assign mask        = AW'(size - CW'(1));
	assign ptr         = wptr_q & mask;
	assign window_full = (count_q >= size);

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;

	assign new_ext = {{(SW - SAMPLE_W){sample_s1[SAMPLE_W-1]}}, sample_s1};
	assign old_ext = window_full ? {{(SW - SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q} : '0;

	assign push      = (state_q == ST_PUSH) && !full;
	assign push_data = {sum_q, count_q};

	// Sample store: read at accept, written back in the next cycle (ST_UPD) at the same slot.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= store_q[ptr];
		end
		if (state_q == ST_UPD) begin
			store_q[ptr_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			ptr_s1    <= ptr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_log2_q <= WINDOW_LOG2_RESET;
			sum_q         <= '0;
			count_q       <= '0;
			wptr_q        <= '0;
		end else begin
			if (window_log2_we) begin
				window_log2_q <= window_log2;
				sum_q         <= '0;
				count_q       <= '0;
				wptr_q        <= '0;
			end else if (state_q == ST_UPD) begin
				sum_q  <= sum_q - old_ext + new_ext;
				wptr_q <= (ptr_s1 + AW'(1)) & mask;
				if (!window_full) begin
					count_q <= count_q + CW'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_PUSH;
				ST_PUSH: if (!full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The fill count saturates at the window size and never runs past it.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= size)
		else $error("fill count above window size");
	// Every pushed entry carries a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> (count_q != '0))
		else $error("zero divisor pushed");

endmodule

// ----- src/wma_div.sv -----
module wma_div
	import wma_pkg::*;
#(
	parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_LOG2_DEF,
	localparam int CW = MAX_WINDOW_LOG2 + 1,
	localparam int SW = SAMPLE_W + MAX_WINDOW_LOG2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  logic [SW+CW-1:0]    pop_data,
	output logic                pop,
	output logic                average_valid,
	input  logic                average_stall,
	output logic [SAMPLE_W-1:0] average
);

	localparam int STW = $clog2(SW + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]          state_q;
	logic [STW-1:0]      step_q;
	logic                neg_q;
	logic [CW-1:0]       div_q;
	logic [CW-1:0]       rem_q;
	logic [SW-1:0]       quo_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] average_q;

	logic [SW-1:0] in_sum;
	logic [CW-1:0] in_count;
	logic [CW:0]   trial;
	logic [CW:0]   diff;
	logic          ge;
	logic [SW-1:0] signed_quo;
	logic          out_load;

	assign in_sum   = pop_data[SW+CW-1:CW];
	assign in_count = pop_data[CW-1:0];
	assign pop      = (state_q == ST_IDLE) && !empty;

	// One restoring step: bring down the next dividend bit, subtract if it fits.
	assign trial = {rem_q, quo_q[SW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	assign signed_quo = neg_q ? (~quo_q + SW'(1)) : quo_q;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !average_stall);

	assign average_valid = out_valid_q;
	assign average       = average_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_q <= in_sum[SW-1];
			div_q <= in_count;
			rem_q <= '0;
			quo_q <= in_sum[SW-1] ? (~in_sum + SW'(1)) : in_sum;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end
		if (out_load) begin
			average_q <= signed_quo[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (average_stall == 1'b0) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STW'(1);
					if (step_q == STW'(SW - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The iteration count stays inside the dividend width.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (step_q < STW'(SW)))
		else $error("divider ran past its last step");
	// A result is only loaded into the output register when that register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !average_stall))
		else $error("output register overwritten");

endmodule

// ----- src/warmup_moving_average.sv -----
// Moving average over the last 2^window_log2 signed 16-bit samples, with exact
// averages while the window is still filling: each item returns the running sum
// divided by the number of samples held, truncated toward zero. Writing
// window_log2 restarts the window (sum, count and write slot cleared); values
// above MAX_WINDOW_LOG2 act as MAX_WINDOW_LOG2. Write it only while no item is in
// flight. The front takes an item, reads the old sample from its store, updates
// the running sum and count in its update state and drops the pair into a
// two-entry queue in its push state, waiting there while the queue is full. The
// back divides with a bit-serial restoring divider, one quotient bit per cycle,
// and takes the next item only once the last result has left for the output
// register. A finished result waits in that register, so the divider can work
// on the next item while the consumer stalls, and the front can fill the queue.
// The sample store needs no clearing after reset: an entry read from it is used
// only after the window has wrapped, and by then it has been written.
module warmup_moving_average
	import wma_pkg::*;
#(
	parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_LOG2_DEF,
	localparam int CW = MAX_WINDOW_LOG2 + 1,
	localparam int SW = SAMPLE_W + MAX_WINDOW_LOG2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                window_log2_we,
	input  logic [CFG_W-1:0]    window_log2,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                average_valid,
	input  logic                average_stall,
	output logic [SAMPLE_W-1:0] average
);

	// Handoff between the window update and the divider: running sum and count.
	logic               push;
	logic [SW+CW-1:0]   push_data;
	logic               full;
	logic               pop;
	logic [SW+CW-1:0]   pop_data;
	logic               empty;

	// Front: sample store, running sum, fill count and write slot.
	wma_front #(
		.MAX_WINDOW_LOG2(MAX_WINDOW_LOG2)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.window_log2_we(window_log2_we),
		.window_log2   (window_log2),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.push          (push),
		.push_data     (push_data),
		.full          (full)
	);

	// Short queue so the front can run ahead while the divider is busy.
	wma_queue #(
		.WIDTH(SW + CW),
		.DEPTH(QUEUE_DEPTH_DEF)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	// Back: signed sum divided by the count, then the output register.
	wma_div #(
		.MAX_WINDOW_LOG2(MAX_WINDOW_LOG2)
	) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.average_valid(average_valid),
		.average_stall(average_stall),
		.average      (average)
	);

	// Accepting an item never coincides with a window restart.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(window_log2_we && sample_valid && !sample_stall))
		else $error("window restart during item accept");

endmodule

// ----- dv/warmup_moving_average_tb.sv -----
`timescale 1ns / 100ps

// Keeps a predicted copy of the window: the sample history, the running total,
// the next slot and the number of samples held. Every accepted sample adds one
// average to the queue of averages due. Every average that leaves the block is
// checked against the oldest one in that queue.
class running_average_book;
	localparam int WIDEST_LOG2 = wma_pkg::MAX_WINDOW_LOG2_DEF;

	logic signed [15:0] history [1 << WIDEST_LOG2];
	int running_total;
	int next_slot;
	int held;
	logic [wma_pkg::CFG_W-1:0] window_reg;
	logic [15:0] averages_due [$];
	int errors;

	function new();
		errors = 0;
		foreach (history[i]) begin
			history[i] = '0;
		end
		restart(wma_pkg::WINDOW_LOG2_RESET);
	endfunction

	// A write of the window register clears the total, the slot and the count.
	// The history keeps its contents.
	function void restart(logic [wma_pkg::CFG_W-1:0] setting);
		window_reg = setting;
		running_total = 0;
		next_slot = 0;
		held = 0;
	endfunction

	function int pending();
		return averages_due.size();
	endfunction

	function void take_sample(logic signed [15:0] s);
		int span_log2;
		int span;
		int slot;
		int quotient;
		// Register values above the widest window act as the widest window.
		span_log2 = (window_reg > WIDEST_LOG2) ? WIDEST_LOG2 : int'(window_reg);
		span = 1 << span_log2;
		slot = next_slot & (span - 1);
		if (held >= span) begin
			running_total -= history[slot];
		end
		running_total += s;
		history[slot] = s;
		next_slot = (slot + 1) & (span - 1);
		if (held < span) begin
			held++;
		end
		// Integer division on int truncates toward zero, as the block does.
		quotient = running_total / held;
		averages_due.push_back(quotient[15:0]);
	endfunction

	task report(string what);
		$display("%0.1f ns: %s", $realtime, what);
		errors++;
	endtask

	task check_average(logic [15:0] got);
		logic [15:0] want;
		if (averages_due.size() == 0) begin
			report($sformatf("average %0d arrived with none due", $signed(got)));
		end else begin
			want = averages_due.pop_front();
			if (got !== want) begin
				report($sformatf("average %0d, predicted %0d", $signed(got), $signed(want)));
			end
		end
	endtask

	task flush();
		while (averages_due.size() != 0) begin
			report($sformatf("average %0d never arrived",
				$signed(averages_due.pop_front())));
		end
	endtask
endclass

module warmup_moving_average_tb;
	import wma_pkg::*;

	// Every input of the block starts at a known value.
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                window_log2_we = 1'b0;
	logic [CFG_W-1:0]    window_log2 = '0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                average_valid;
	logic                average_stall = 1'b0;
	logic [SAMPLE_W-1:0] average;

	// Odds of a gap (per item) or a stall burst (per cycle): one in N, none when zero.
	// The main sequence changes them per phase; the last phase runs clean.
	int gap_odds = 0;
	int stall_odds = 0;

	running_average_book book = new();

	// The phases after the directed part. Window settings cover both ends of
	// the range, several settings above the widest window that saturate, and
	// all-zero and all-one register values. Short phases at large windows
	// restart the window before it fills; the long phase at the widest window
	// wraps the store twice.
	localparam int PHASES = 12;
	int phase_window [PHASES] = '{0, 1, 2, 8, 4, 15, 5, 9, 6, 7, 12, 3};
	int phase_items [PHASES] = '{40, 40, 50, 520, 60, 300, 80, 60, 150, 200, 40, 60};

	// Directed samples at the reset window of eight: a full window at the
	// positive extreme, then the negative extreme pushed through it, then
	// small values of both signs where truncation toward zero matters, and
	// alternating bit patterns.
	logic [15:0] directed [24] = '{
		16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
		16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
		16'h0000, 16'hffff, 16'h0001, 16'hffff, 16'h0003, 16'hfffb, 16'h5555, 16'haaaa
	};

	warmup_moving_average dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_log2_we (window_log2_we),
		.window_log2    (window_log2),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.average_valid  (average_valid),
		.average_stall  (average_stall),
		.average        (average)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Outputs are sampled at the rising edge, before any update of that edge
	// lands, so what is read is what the block showed during the cycle.
	always @(posedge clk) begin
		if (arst_n && average_valid && !average_stall) begin
			book.check_average(average);
		end
	end

	// Output stalls come in random bursts. The stall is raised and
	// lowered at different edges, so it never gets two updates in one step.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
				average_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				average_stall <= 1'b0;
			end
		end
	end

	// Presents one item and holds it until the block takes it. The predictor
	// learns of the sample at the edge where it is accepted. Valid stays high
	// when the next item follows at once.
	task send_sample(input logic [15:0] value);
		sample_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (sample_stall);
		book.take_sample($signed(value));
	endtask

	// A gap on the input side: valid drops for a random burst.
	task maybe_pause();
		if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Random sample content. The high and low styles hold the running total
	// near its extremes for long stretches; the mixed style spreads over the
	// whole range with the extremes and small values of both signs mixed in.
	function logic [15:0] pick_sample(int style);
		logic [15:0] v;
		v = 16'($urandom());
		case (style)
			1: begin
				if ($urandom_range(0, 9) < 8) begin
					v = 16'h7fff - 16'($urandom_range(0, 3));
				end
			end
			2: begin
				if ($urandom_range(0, 9) < 8) begin
					v = 16'h8000 + 16'($urandom_range(0, 3));
				end
			end
			default: begin
				case ($urandom_range(0, 7))
					0: v = 16'h7fff;
					1: v = 16'h8000;
					2: v = 16'($urandom_range(0, 6)) - 16'd3;
					default: ;
				endcase
			end
		endcase
		return v;
	endfunction

	// The register is written only with nothing in flight: every predicted
	// average has come out and the divider has settled.
	task write_window(input logic [CFG_W-1:0] setting);
		while (book.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		window_log2_we <= 1'b1;
		window_log2 <= setting;
		@(posedge clk);
		window_log2_we <= 1'b0;
		book.restart(setting);
	endtask

	task run_phase(input int setting, input int count, input bit quiet);
		int style;
		int odds_menu [4];
		odds_menu = '{0, 2, 8, 30};
		style = 0;
		gap_odds = 0;
		stall_odds = 0;
		write_window(setting[CFG_W-1:0]);
		if (!quiet) begin
			gap_odds = odds_menu[$urandom_range(0, 3)];
			stall_odds = odds_menu[$urandom_range(0, 3)];
		end
		for (int n = 0; n < count; n++) begin
			// A fresh content style every 64 items keeps long phases varied.
			if (n % 64 == 0) begin
				style = $urandom_range(0, 2);
			end
			send_sample(pick_sample(style));
			maybe_pause();
		end
		sample_valid <= 1'b0;
	endtask

	initial begin
		int guard;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset window, with both sides idling now and
		// then so the first items already meet stalls.
		gap_odds = 8;
		stall_odds = 8;
		foreach (directed[i]) begin
			send_sample(directed[i]);
			maybe_pause();
		end
		sample_valid <= 1'b0;

		// Random phases; the last one runs without gaps or stalls.
		for (int p = 0; p < PHASES; p++) begin
			run_phase(phase_window[p], phase_items[p], p == PHASES - 1);
		end

		guard = 0;
		while (book.pending() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		// Wait on after the last due average, so a stray extra average is caught.
		repeat (64) @(posedge clk);
		book.flush();
		if (book.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// The slowest correct run ends well before this watchdog gives up.
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- warmup_moving_average.f -----
src/wma_pkg.sv
src/wma_queue.sv
src/wma_front.sv
src/wma_div.sv
src/warmup_moving_average.sv
dv/warmup_moving_average_tb.sv
